// File: design/keypad_code_lock_macros.svh
`ifndef KEYPAD_CODE_LOCK_MACROS_SVH
`define KEYPAD_CODE_LOCK_MACROS_SVH

// Same-cycle check: when ante holds, cons holds at the same edge.
`define KCL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle check: when ante holds, cons holds at the following edge.
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/kcl_pkg.sv
package kcl_pkg;

	// transaction kinds
	localparam logic [2:0] KIND_KEY     = 3'd0;
	localparam logic [2:0] KIND_TICK    = 3'd1;
	localparam logic [2:0] KIND_DROP    = 3'd2;
	localparam logic [2:0] KIND_RESTART = 3'd3;
	localparam logic [2:0] KIND_TBLOCK  = 3'd4;
	localparam logic [2:0] KIND_BLOCK   = 3'd5;
	localparam logic [2:0] KIND_UNBLOCK = 3'd6;

	// result events
	localparam logic [1:0] EVT_NONE    = 2'd0;
	localparam logic [1:0] EVT_SUCCESS = 2'd1;
	localparam logic [1:0] EVT_FAIL    = 2'd2;

	// configuration register indexes
	localparam logic CFG_CODE_LENGTH = 1'b0;
	localparam logic CFG_CODE_DIGITS = 1'b1;

	localparam logic [3:0] KEY_MAX = 4'd11;
	localparam logic [3:0] CODE_LENGTH_RST = 4'd4;
	localparam int CODE_NIBBLES = 8;

	typedef struct packed {
		logic done;
		logic match;
	} cmp_res_t;

endpackage

// File: design/kcl_match.sv
module kcl_match #(
	parameter  int MAX_DIGITS = 8,
	localparam int CW         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CW-1:0]             wr_idx,
	input  logic [3:0]                wr_key,
	input  logic                      start,
	input  logic [CW-1:0]             len_m1,
	input  logic [31:0]               code_digits,
	output kcl_pkg::cmp_res_t         res
);

	logic [3:0]    store_q [MAX_DIGITS];
	logic [3:0]    code_nib [MAX_DIGITS];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] last_q;
	logic          busy_q;
	logic          ok_q;
	logic          done_q;
	logic          match_q;
	logic          eq;

	// digits beyond the code register compare against zero
	for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_nib
		if (g < kcl_pkg::CODE_NIBBLES) begin : g_in
			assign code_nib[g] = code_digits[4*g +: 4];
		end else begin : g_out
			assign code_nib[g] = 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_idx] <= wr_key;
		end
	end

	assign eq = (store_q[cnt_q] == code_nib[cnt_q]);

	// one digit per cycle through the shared comparator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			last_q  <= '0;
			ok_q    <= 1'b0;
			done_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				last_q <= len_m1;
				ok_q   <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == last_q) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					match_q <= ok_q & eq;
				end else begin
					cnt_q <= cnt_q + CW'(1);
					ok_q  <= ok_q & eq;
				end
			end
		end
	end

	assign res.done  = done_q;
	assign res.match = match_q;

endmodule

// File: design/keypad_code_lock.sv
// Results: one per accepted transaction, registered in the cycle after accept, except for a key
// press that completes an attempt, loaded once kcl_match has compared the effective code length.
// Throughput: one transaction per cycle while idle with no result waiting on out_ready; a compare
// holds off input and walks the stored attempt one digit per cycle through one comparator.
// Reset (arst_n low, asynchronous): flags, index, tick counters cleared, code_length = 4,
// code_digits = 0; the attempt store is not cleared and needs no clearing pass.
`include "keypad_code_lock_macros.svh"

module keypad_code_lock #(
	parameter int MAX_DIGITS = 8,
	parameter int TICK_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [3:0]  key_code,
	input  logic [31:0] block_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        solved,
	output logic        blocked,
	output logic [1:0]  event_res,
	output logic [3:0]  entered_count
);

	localparam int IW = $clog2(MAX_DIGITS + 1);
	localparam int CW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CMP  = 2'b10
	} state_t;

	state_t               state_q;
	logic [3:0]           code_length_q;
	logic [31:0]          code_digits_q;
	logic [IW-1:0]        entry_index_q;
	logic                 solved_q;
	logic                 blocked_q;
	logic                 timed_q;
	logic [TICK_BITS-1:0] elapsed_q;
	logic [TICK_BITS-1:0] duration_q;

	logic                 out_valid_q;
	logic                 out_solved_q;
	logic                 out_blocked_q;
	logic [1:0]           out_event_q;
	logic [3:0]           out_count_q;

	logic                 accept;
	logic [4:0]           eff_len;
	logic [CW-1:0]        len_m1;
	logic                 idx_room;
	logic [IW-1:0]        idx_inc;
	logic [TICK_BITS-1:0] tick_inc;

	logic                 solved_n;
	logic                 blocked_n;
	logic                 timed_n;
	logic [IW-1:0]        idx_n;
	logic [TICK_BITS-1:0] elapsed_n;
	logic [TICK_BITS-1:0] duration_n;
	logic                 wr_key;
	logic                 start_cmp;

	kcl_pkg::cmp_res_t    res;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// clamp the configured length to 1..MAX_DIGITS
	always_comb begin
		if (code_length_q == 4'd0) begin
			eff_len = 5'd1;
		end else if ({1'b0, code_length_q} > 5'(MAX_DIGITS)) begin
			eff_len = 5'(MAX_DIGITS);
		end else begin
			eff_len = {1'b0, code_length_q};
		end
	end

	assign len_m1   = CW'(eff_len - 5'd1);
	assign idx_room = (5'(entry_index_q) < 5'(MAX_DIGITS));
	assign idx_inc  = idx_room ? entry_index_q + IW'(1) : entry_index_q;
	// saturate at all ones
	assign tick_inc = (elapsed_q != '1) ? elapsed_q + TICK_BITS'(1) : elapsed_q;

	always_comb begin
		solved_n   = solved_q;
		blocked_n  = blocked_q;
		timed_n    = timed_q;
		idx_n      = entry_index_q;
		elapsed_n  = elapsed_q;
		duration_n = duration_q;
		wr_key     = 1'b0;
		start_cmp  = 1'b0;
		case (kind)
			kcl_pkg::KIND_KEY: begin
				if (!blocked_q && !solved_q && key_code <= kcl_pkg::KEY_MAX) begin
					wr_key = idx_room;
					idx_n  = idx_inc;
					if (5'(idx_inc) >= eff_len) begin
						start_cmp = 1'b1;
					end
				end
			end
			kcl_pkg::KIND_TICK: begin
				if (blocked_q && timed_q) begin
					elapsed_n = tick_inc;
					if (tick_inc > duration_q) begin
						blocked_n = 1'b0;
						timed_n   = 1'b0;
					end
				end
			end
			kcl_pkg::KIND_DROP: begin
				solved_n = 1'b0;
				idx_n    = '0;
			end
			kcl_pkg::KIND_RESTART: begin
				if (!solved_q) begin
					idx_n = '0;
				end
			end
			kcl_pkg::KIND_TBLOCK: begin
				elapsed_n  = '0;
				duration_n = TICK_BITS'(block_ticks);
				blocked_n  = 1'b1;
				timed_n    = 1'b1;
			end
			kcl_pkg::KIND_BLOCK: begin
				blocked_n = 1'b1;
				timed_n   = 1'b0;
			end
			kcl_pkg::KIND_UNBLOCK: begin
				blocked_n = 1'b0;
				timed_n   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	kcl_match #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept && wr_key),
		.wr_idx     (entry_index_q[CW-1:0]),
		.wr_key     (key_code),
		.start      (accept && start_cmp),
		.len_m1     (len_m1),
		.code_digits(code_digits_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			code_length_q <= kcl_pkg::CODE_LENGTH_RST;
			code_digits_q <= '0;
			entry_index_q <= '0;
			solved_q      <= 1'b0;
			blocked_q     <= 1'b0;
			timed_q       <= 1'b0;
			elapsed_q     <= '0;
			duration_q    <= '0;
			out_valid_q   <= 1'b0;
			out_solved_q  <= 1'b0;
			out_blocked_q <= 1'b0;
			out_event_q   <= kcl_pkg::EVT_NONE;
			out_count_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kcl_pkg::CFG_CODE_LENGTH: code_length_q <= cfg_data[3:0];
					kcl_pkg::CFG_CODE_DIGITS: code_digits_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// load a new result, or drop the one taken
			if ((accept && !start_cmp) || (state_q == ST_CMP && res.done)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				solved_q      <= solved_n;
				blocked_q     <= blocked_n;
				timed_q       <= timed_n;
				entry_index_q <= idx_n;
				elapsed_q     <= elapsed_n;
				duration_q    <= duration_n;
				if (start_cmp) begin
					state_q <= ST_CMP;
				end else begin
					out_solved_q  <= solved_n;
					out_blocked_q <= blocked_n;
					out_event_q   <= kcl_pkg::EVT_NONE;
					out_count_q   <= 4'(idx_n);
				end
			end

			if (state_q == ST_CMP && res.done) begin
				state_q       <= ST_IDLE;
				out_blocked_q <= blocked_q;
				if (res.match) begin
					solved_q     <= 1'b1;
					out_solved_q <= 1'b1;
					out_event_q  <= kcl_pkg::EVT_SUCCESS;
					out_count_q  <= 4'(entry_index_q);
				end else begin
					entry_index_q <= '0;
					out_solved_q  <= solved_q;
					out_event_q   <= kcl_pkg::EVT_FAIL;
					out_count_q   <= 4'd0;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign solved        = out_solved_q;
	assign blocked       = out_blocked_q;
	assign event_res     = out_event_q;
	assign entered_count = out_count_q;

	`KCL_ASSERT_IMPL(a_success_solved, out_valid && event_res == kcl_pkg::EVT_SUCCESS, solved, "success without solved")
	`KCL_ASSERT_IMPL(a_fail_clears, out_valid && event_res == kcl_pkg::EVT_FAIL, entered_count == 4'd0, "failure left digits")
	`KCL_ASSERT_IMPL(a_cmp_no_out, state_q == ST_CMP, !out_valid_q, "result pending during compare")
	`KCL_ASSERT_NEXT(a_drop_result, accept && kind == kcl_pkg::KIND_DROP, out_valid && !solved && entered_count == 4'd0, "drop result wrong")

endmodule
